@@ hw/rtl/rgb_led_matrix_column_scanner_assert.svh @@
// Assertion helpers for the column scanner checker.
// Both expect clk_i and rst_ni in scope and are disabled while reset is low.
`ifndef RGB_LED_MATRIX_COLUMN_SCANNER_ASSERT_SVH
`define RGB_LED_MATRIX_COLUMN_SCANNER_ASSERT_SVH

// Same-edge implication.
`define LMCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked at the following edge.
`define LMCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/lmcs_pkg.sv @@
`default_nettype none

package lmcs_pkg;

  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 16;

  localparam int LEVEL_W  = 12;
  localparam int ROW_W    = 3;
  localparam int ROW_SLOTS = 8;

  // Request kinds carried on s_axis_tuser
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic start;   // request accepted this cycle
    logic finish;  // update scan state and load the result this cycle
  } ctrl_cmd_t;

  // Result fields, column_address in the lowest bits
  typedef struct packed {
    logic       latch;
    logic       data_valid;
    logic       serial_data;
    logic       enable;
    logic       blank;
    logic [3:0] column_address;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/rgb_led_matrix_column_scanner.sv @@
// Channel   Dir  Signals                                   Contents
// s_axis    in   s_axis_tvalid/tready/tdata/tuser           pixel write, clear or scan tick
// m_axis    out  m_axis_tvalid/tready/tdata                 column address and driver strobes
// cfg       in   cfg_wr_en_i/cfg_wr_data_i                  dwell_ticks
//
// For every request, the accept edge reads the pixel word for the current
// scan position from the pixel RAM, the next edge updates the scan state and loads the
// result register. One result per request; it waits in the output register while
// m_axis stalls, and a new request is taken in the same cycle that result drains.
// Reset puts the scan at column 0, start of the shift stream; per-pixel valid flags
// make the framebuffer read as zero at once, with no clearing pass.
`default_nettype none

module rgb_led_matrix_column_scanner #(
  parameter int COLUMNS         = 16,
  parameter int ROWS_PER_COLUMN = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Request channel
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pixel_x[3:0], pixel_y[6:4], red[18:7], green[30:19], blue[42:31], zero[47:43]
  input  wire logic [lmcs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // kind[1:0]
  input  wire logic [lmcs_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  // Result channel
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // column_address[3:0], blank[4], enable[5], serial_data[6], data_valid[7],
  // latch[8], zero[15:9]
  output logic [lmcs_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  // Configuration: dwell_ticks
  input  wire logic                             cfg_wr_en_i,
  input  wire logic [15:0]                      cfg_wr_data_i
);
  import lmcs_pkg::*;

  ctrl_cmd_t cmd;
  result_t   result;

  // Sequence each request: accept, then finish in the cycle after.
  lmcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Pixel RAM, scan counters, dwell timer and the result register.
  lmcs_datapath #(
    .COLUMNS         (COLUMNS),
    .ROWS_PER_COLUMN (ROWS_PER_COLUMN)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .kind_i        (s_axis_tuser),
    .pixel_x_i     (s_axis_tdata[3:0]),
    .pixel_y_i     (s_axis_tdata[6:4]),
    .red_i         (s_axis_tdata[18:7]),
    .green_i       (s_axis_tdata[30:19]),
    .blue_i        (s_axis_tdata[42:31]),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .result_o      (result)
  );

  // Pad the result fields out to whole bytes.
  assign m_axis_tdata = {{(M_TDATA_W - $bits(result_t)){1'b0}}, result};

endmodule

`default_nettype wire

@@ hw/rtl/lmcs_ctrl.sv @@
`default_nettype none

module lmcs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output lmcs_pkg::ctrl_cmd_t    cmd_o
);
  import lmcs_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic start;

  // Take a request only when the result slot is free or drains this cycle.
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign start      = in_valid_i && in_ready_o;

  assign cmd_o.start  = start;
  assign cmd_o.finish = (state_q == ST_EXEC);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ hw/rtl/lmcs_datapath.sv @@
`default_nettype none

module lmcs_datapath #(
  parameter int COLUMNS         = 16,
  parameter int ROWS_PER_COLUMN = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lmcs_pkg::ctrl_cmd_t cmd_i,
  input  wire logic [1:0]          kind_i,
  input  wire logic [3:0]          pixel_x_i,
  input  wire logic [2:0]          pixel_y_i,
  input  wire logic [11:0]         red_i,
  input  wire logic [11:0]         green_i,
  input  wire logic [11:0]         blue_i,
  input  wire logic                cfg_wr_en_i,
  input  wire logic [15:0]         cfg_wr_data_i,
  output lmcs_pkg::result_t        result_o
);
  import lmcs_pkg::*;

  localparam int ColW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int AddrW = ColW + ROW_W;
  localparam int Depth = COLUMNS * ROW_SLOTS;
  localparam int WordW = 3 * LEVEL_W;

  localparam logic [ColW-1:0] LastCol = ColW'(COLUMNS - 1);

  localparam logic [1:0] PH_SHIFT = 2'd0;
  localparam logic [1:0] PH_LATCH = 2'd1;
  localparam logic [1:0] PH_DWELL = 2'd2;

  localparam logic [1:0] SUB_GREEN = 2'd0;
  localparam logic [1:0] SUB_RED   = 2'd1;
  localparam logic [1:0] SUB_BLUE  = 2'd2;

  localparam logic [ROW_W-1:0] ROW_FIRST = ROW_W'(ROW_SLOTS - 1);
  localparam logic [3:0]       BIT_FIRST = 4'(LEVEL_W - 1);

  // Pixel memory, one word per pixel: {blue, green, red}
  logic [WordW-1:0] mem [Depth];
  logic [Depth-1:0] valid_q;
  logic [WordW-1:0] rd_data_q;
  logic             rd_valid_q;
  logic [1:0]       kind_q;

  logic [ColW-1:0]  col_q, col_d, col_next;
  logic [1:0]       phase_q, phase_d, phase_eff;
  logic [ROW_W-1:0] row_q, row_d;
  logic [1:0]       sub_q, sub_d;
  logic [3:0]       bit_q, bit_d;
  logic [15:0]      dwell_cnt_q, dwell_cnt_d, dwell_inc;
  logic [15:0]      dwell_ticks_q;

  logic             in_range, mem_we, clear;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [LEVEL_W-1:0] level;
  logic             stream_bit;
  result_t          res_d, result_q;

  assign in_range = ({1'b0, pixel_x_i} < 5'(COLUMNS)) &&
                    ({1'b0, pixel_y_i} < 4'(ROWS_PER_COLUMN));
  assign mem_we   = cmd_i.start && (kind_i == KIND_WRITE) && in_range;
  assign clear    = cmd_i.start && (kind_i == KIND_CLEAR);
  assign wr_addr  = {pixel_x_i[ColW-1:0], pixel_y_i};
  assign rd_addr  = {col_q, row_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= {blue_i, green_i, red_i};
    end
    if (cmd_i.start) begin
      rd_data_q  <= mem[rd_addr];
      rd_valid_q <= valid_q[rd_addr];
      kind_q     <= kind_i;
    end
  end

  // Pixel valid flags: a pixel never written since reset or clear reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear) begin
      valid_q <= '0;
    end else if (mem_we) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    case (sub_q)
      SUB_BLUE: level = rd_data_q[3*LEVEL_W-1:2*LEVEL_W];
      SUB_RED:  level = rd_data_q[LEVEL_W-1:0];
      default:  level = rd_data_q[2*LEVEL_W-1:LEVEL_W];
    endcase
  end

  assign stream_bit = rd_valid_q && ({1'b0, row_q} < 4'(ROWS_PER_COLUMN)) && level[bit_q];

  assign phase_eff = ((phase_q == PH_LATCH) || (phase_q == PH_DWELL)) ? phase_q : PH_SHIFT;
  assign col_next  = (col_q == LastCol) ? '0 : col_q + 1'b1;
  assign dwell_inc = dwell_cnt_q + 16'd1;

  always_comb begin
    col_d       = col_q;
    phase_d     = phase_q;
    row_d       = row_q;
    sub_d       = sub_q;
    bit_d       = bit_q;
    dwell_cnt_d = dwell_cnt_q;

    res_d.column_address = 4'(col_q);
    res_d.blank          = (phase_eff != PH_DWELL);
    res_d.enable         = (phase_eff != PH_DWELL);
    res_d.serial_data    = 1'b0;
    res_d.data_valid     = 1'b0;
    res_d.latch          = 1'b0;

    if (cmd_i.finish && (kind_q == KIND_TICK)) begin
      case (phase_eff)
        PH_LATCH: begin
          res_d.latch = 1'b1;
          dwell_cnt_d = '0;
          if (dwell_ticks_q == 16'd0) begin
            col_d   = col_next;
            phase_d = PH_SHIFT;
          end else begin
            phase_d = PH_DWELL;
          end
        end
        PH_DWELL: begin
          dwell_cnt_d = dwell_inc;
          if (dwell_inc >= dwell_ticks_q) begin
            dwell_cnt_d = '0;
            col_d       = col_next;
            phase_d     = PH_SHIFT;
          end
        end
        default: begin
          // Walk bits MSB first, channels blue/red/green of each row, rows downward.
          res_d.serial_data = stream_bit;
          res_d.data_valid  = 1'b1;
          phase_d           = PH_SHIFT;
          if (bit_q != 4'd0) begin
            bit_d = bit_q - 4'd1;
          end else begin
            bit_d = BIT_FIRST;
            if (sub_q != SUB_GREEN) begin
              sub_d = sub_q - 2'd1;
            end else begin
              sub_d = SUB_BLUE;
              if (row_q != '0) begin
                row_d = row_q - 1'b1;
              end else begin
                row_d   = ROW_FIRST;
                phase_d = PH_LATCH;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q         <= '0;
      phase_q       <= PH_SHIFT;
      row_q         <= ROW_FIRST;
      sub_q         <= SUB_BLUE;
      bit_q         <= BIT_FIRST;
      dwell_cnt_q   <= '0;
      dwell_ticks_q <= 16'd250;
    end else begin
      col_q       <= col_d;
      phase_q     <= phase_d;
      row_q       <= row_d;
      sub_q       <= sub_d;
      bit_q       <= bit_d;
      dwell_cnt_q <= dwell_cnt_d;
      if (cfg_wr_en_i) begin
        dwell_ticks_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      result_q <= res_d;
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

@@ hw/rtl/lmcs_checker.sv @@
`default_nettype none
`include "rgb_led_matrix_column_scanner_assert.svh"

module lmcs_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [lmcs_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [lmcs_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import lmcs_pkg::*;

  logic in_take;
  logic non_tick;
  logic quiet;
  logic shifting;
  logic out_stall;
  logic res_blank, res_enable, res_dvalid, res_latch;

  assign res_blank  = m_axis_tdata[4];
  assign res_enable = m_axis_tdata[5];
  assign res_dvalid = m_axis_tdata[7];
  assign res_latch  = m_axis_tdata[8];

  assign in_take   = s_axis_tvalid && s_axis_tready;
  assign non_tick  = in_take && (s_axis_tuser != KIND_TICK);
  assign quiet     = m_axis_tvalid && !m_axis_tdata[6] && !res_dvalid && !res_latch;
  assign shifting  = m_axis_tvalid && res_dvalid;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // Decoder enable always follows blank.
  `LMCS_ASSERT_NOW(a_en_blank, m_axis_tvalid, res_enable == res_blank, "enable differs from blank")

  // A shifted bit and a latch strobe never share a result, and shifting is blanked.
  `LMCS_ASSERT_NOW(a_shift_blanked, shifting, res_blank && !res_latch, "bad shift strobes")

  // Any non-tick request (write, clear or the unused kind) yields a result with no stream activity.
  `LMCS_ASSERT_NOW(a_non_tick_quiet, non_tick, ##2 quiet, "non-tick request drove stream outputs")

  // A stalled result holds.
  `LMCS_ASSERT_NEXT(a_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "stall not held")

endmodule

bind rgb_led_matrix_column_scanner lmcs_checker u_lmcs_checker (.*);

`default_nettype wire
